>>> src/drw_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed-point constants of the diode rectifier waveshaper
package drw_pkg;

  localparam int A_W         = 17;
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;
  localparam int Q16_SHIFT   = 16;
  localparam int GAIN_K      = 30;
  localparam int DEN_K       = 21;

  localparam int T_W         = 24;
  localparam int FR_BITS     = 22;
  localparam int GAIN_W      = 21;
  localparam int DEN_W       = 21;
  localparam int SCALE_SHIFT = 20;
  localparam int SMAG_W      = T_W + GAIN_W - SCALE_SHIFT;
  localparam int S_W         = SMAG_W + 1;
  localparam int O2_W        = S_W + 1;
  localparam int N_W         = O2_W - 1;
  localparam int M_W         = N_W + Q16_SHIFT;
  localparam int Q_W         = 20;
  localparam int R_W         = M_W - Q_W;
  localparam int DIV_STEP    = 2;

  localparam int FRAC_BITS   = 19;
  localparam int O3_W        = FRAC_BITS + 2;
  localparam int O3_LIM      = 1 << FRAC_BITS;
  localparam int KNEE_Q19    = 367002;
  localparam int BREAK_Q19   = -6291456;
  localparam int OFFSET_Q19  = 24 << FRAC_BITS;

  typedef struct packed {
    logic [A_W-1:0]    a;
    logic [GAIN_W-1:0] gain;
    logic [DEN_W-1:0]  den;
  } cfg_t;

  typedef struct packed {
    logic [M_W-1:0] m;
    logic           sat;
    logic           neg;
  } dvd_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           sat;
    logic           neg;
  } quo_t;

endpackage

>>> src/drw_shaper.sv
`timescale 1ns / 1ps
// Tanh lookup, drive gain, diode knee and dividend set-up stages
module drw_shaper #(
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int SAMPLE_WIDTH     = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  drw_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_x,
  output drw_pkg::dvd_t                  out_d
);
  import drw_pkg::*;

  localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH);
  localparam int TAB_AW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int POS_W  = FR_BITS + IDX_W;
  localparam int MAGX_W = (SAMPLE_WIDTH > FR_BITS + 1) ? SAMPLE_WIDTH : FR_BITS + 1;
  localparam int PT_W   = T_W + FR_BITS;
  localparam int PG_W   = T_W + GAIN_W;

  typedef logic [T_W-1:0] tab_t [TANH_TABLE_DEPTH+1];

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] quo;
    logic [63:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] term;
    logic [63:0] sum_p;
    logic [63:0] sum_n;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    int          n;
    int          k;
    term  = 64'd1 << 58;
    sum_p = term;
    sum_n = '0;
    for (n = 1; n < 48; n++) begin
      if (term != '0) begin
        term = udiv(term * 64'd16, 64'(TANH_TABLE_DEPTH) * 64'(n));
        if ((n & 1) != 0) begin
          sum_n = sum_n + term;
        end else begin
          sum_p = sum_p + term;
        end
      end
    end
    r = ((sum_p - sum_n) + (64'd1 << 27)) >> 28;
    e = 64'd1 << 30;
    for (k = 0; k <= TANH_TABLE_DEPTH; k++) begin
      num    = ((64'd1 << 30) - e) << 23;
      den    = (64'd1 << 30) + e;
      tab[k] = T_W'(udiv(num + (den >> 1), den));
      e      = (e * r + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tab();

  logic                           vld1, vld2, vld3, vld4, vld5;
  logic signed [SAMPLE_WIDTH-1:0] x1, x2, x3, x4, x5;
  logic                           neg1, neg2, neg3, neg4;
  logic                           sat1;
  logic [IDX_W-1:0]               idx1;
  logic [FR_BITS-1:0]             fr1, fr2;
  logic [T_W-1:0]                 lo2, diff2, t3;
  logic [SMAG_W-1:0]              smag4;
  logic signed [O2_W-1:0]         o25;

  logic [SAMPLE_WIDTH-1:0] x_u;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [MAGX_W-1:0]       mag_x;
  logic [POS_W-1:0]        pos;
  logic [TAB_AW-1:0]       lo_a;
  logic [TAB_AW-1:0]       hi_a;
  logic [T_W-1:0]          lo_t;
  logic [T_W-1:0]          hi_t;
  logic [T_W-1:0]          diff;
  logic [PT_W-1:0]         prod;
  logic [PG_W-1:0]         pg;
  logic signed [S_W-1:0]   ss;
  logic signed [S_W-1:0]   s;
  logic signed [O2_W-1:0]  o2;
  logic [N_W-1:0]          n6;
  logic [M_W-1:0]          m6;

  assign x_u   = unsigned'(in_x);
  assign mag   = in_x[SAMPLE_WIDTH-1] ? (~x_u + 1'b1) : x_u;
  assign mag_x = MAGX_W'(mag);
  assign pos   = POS_W'(mag_x[FR_BITS-1:0]) * POS_W'(TANH_TABLE_DEPTH);

  assign lo_a = sat1 ? TAB_AW'(TANH_TABLE_DEPTH) : TAB_AW'(idx1);
  assign hi_a = sat1 ? lo_a : lo_a + 1'b1;
  assign lo_t = TANH_TAB[lo_a];
  assign hi_t = TANH_TAB[hi_a];
  assign diff = (hi_t < lo_t) ? '0 : hi_t - lo_t;

  assign prod = PT_W'(diff2) * PT_W'(fr2);

  assign pg = PG_W'(t3) * PG_W'(cfg.gain) + (PG_W'(1) << (SCALE_SHIFT - 1));

  assign ss = signed'(S_W'(smag4));
  assign s  = neg4 ? -ss : ss;

  always_comb begin
    if (s > S_W'(BREAK_Q19)) begin
      if (s > S_W'(KNEE_Q19)) begin
        o2 = O2_W'(s) - O2_W'(KNEE_Q19);
      end else begin
        o2 = '0;
      end
    end else begin
      o2 = (O2_W'(s) <<< 1) + O2_W'(OFFSET_Q19);
    end
  end

  assign n6 = o25[O2_W-1] ? N_W'(-o25) : N_W'(o25);
  assign m6 = (M_W'(n6) << Q16_SHIFT) + M_W'(cfg.den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      vld5      <= vld4;
      out_valid <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1        <= in_x;
      neg1      <= in_x[SAMPLE_WIDTH-1];
      sat1      <= |mag_x[MAGX_W-1:FR_BITS];
      idx1      <= pos[POS_W-1:FR_BITS];
      fr1       <= pos[FR_BITS-1:0];
      x2        <= x1;
      neg2      <= neg1;
      lo2       <= lo_t;
      diff2     <= diff;
      fr2       <= fr1;
      x3        <= x2;
      neg3      <= neg2;
      t3        <= lo2 + prod[PT_W-1:FR_BITS];
      x4        <= x3;
      neg4      <= neg3;
      smag4     <= pg[PG_W-1:SCALE_SHIFT];
      x5        <= x4;
      o25       <= o2;
      out_x     <= x5;
      out_d.m   <= m6;
      out_d.sat <= (m6 >= (M_W'(cfg.den) << Q_W));
      out_d.neg <= o25[O2_W-1];
    end
  end

endmodule

>>> src/drw_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the output attenuation
module drw_divider #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [drw_pkg::DEN_W-1:0]      den,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x,
  input  drw_pkg::dvd_t                  in_d,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_x,
  output drw_pkg::quo_t                  out_q
);
  import drw_pkg::*;

  localparam int STAGES = Q_W / DIV_STEP;

  logic                           vld [STAGES];
  logic signed [SAMPLE_WIDTH-1:0] xs  [STAGES];
  logic                           sat [STAGES];
  logic                           neg [STAGES];
  logic [R_W-1:0]                 rem [STAGES];
  logic [Q_W-1:0]                 quo [STAGES];
  logic [Q_W-1:0]                 low [STAGES];

  logic [R_W-1:0] src_rem [STAGES];
  logic [Q_W-1:0] src_quo [STAGES];
  logic [Q_W-1:0] src_low [STAGES];
  logic [R_W-1:0] rem_next [STAGES];
  logic [Q_W-1:0] quo_next [STAGES];
  logic [Q_W-1:0] low_next [STAGES];

  always_comb begin
    src_rem[0] = in_d.m[M_W-1:Q_W];
    src_quo[0] = '0;
    src_low[0] = in_d.m[Q_W-1:0];
    for (int s = 1; s < STAGES; s++) begin
      src_rem[s] = rem[s-1];
      src_quo[s] = quo[s-1];
      src_low[s] = low[s-1];
    end
  end

  always_comb begin : div_steps
    logic [R_W-1:0] r;
    logic [R_W-1:0] tr;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] l;
    for (int s = 0; s < STAGES; s++) begin
      r = src_rem[s];
      q = src_quo[s];
      l = src_low[s];
      for (int j = 0; j < DIV_STEP; j++) begin
        tr = {r[R_W-2:0], l[Q_W-1]};
        l  = {l[Q_W-2:0], 1'b0};
        if (tr >= R_W'(den)) begin
          r = tr - R_W'(den);
          q = {q[Q_W-2:0], 1'b1};
        end else begin
          r = tr;
          q = {q[Q_W-2:0], 1'b0};
        end
      end
      rem_next[s] = r;
      quo_next[s] = q;
      low_next[s] = l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0]  <= in_x;
      sat[0] <= in_d.sat;
      neg[0] <= in_d.neg;
      for (int s = 1; s < STAGES; s++) begin
        xs[s]  <= xs[s-1];
        sat[s] <= sat[s-1];
        neg[s] <= neg[s-1];
      end
      for (int s = 0; s < STAGES; s++) begin
        rem[s] <= rem_next[s];
        quo[s] <= quo_next[s];
        low[s] <= low_next[s];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_x     = xs[STAGES-1];
  assign out_q.q   = quo[STAGES-1];
  assign out_q.sat = sat[STAGES-1];
  assign out_q.neg = neg[STAGES-1];

endmodule

>>> src/drw_mixer.sv
`timescale 1ns / 1ps
// Output clamp, dry mix, rounding and saturation stages
module drw_mixer #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  drw_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x,
  input  drw_pkg::quo_t                  in_q,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
  import drw_pkg::*;

  localparam int     P1_W = A_W + 1 + O3_W;
  localparam int     P2_W = A_W + 1 + SAMPLE_WIDTH;
  localparam int     V_W  = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int     Y_W  = V_W - Q16_SHIFT + 1;
  localparam longint OMAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint OMIN = -(longint'(1) <<< (SAMPLE_WIDTH - 1));

  logic                           vld1, vld2, vld3, vld4;
  logic signed [O3_W-1:0]         o31, o32, o33;
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic signed [P1_W-1:0]         p12;
  logic signed [P2_W-1:0]         p22;
  logic                           mix2, mix3;
  logic signed [V_W-1:0]          sum3;
  logic signed [Y_W-1:0]          y4;

  logic [Q_W-1:0]          o3mag;
  logic signed [O3_W-1:0]  o3p;
  logic [A_W-1:0]          wet;
  logic [V_W-1:0]          vmag;
  logic [V_W-1:0]          rnd;
  logic signed [Y_W-1:0]   yw;
  logic signed [Y_W-1:0]   ymix;

  assign o3mag = (in_q.sat || in_q.q > Q_W'(O3_LIM)) ? Q_W'(O3_LIM) : in_q.q;
  assign o3p   = signed'(O3_W'(o3mag));
  assign wet   = A_W'(HALF_Q16) - cfg.a;

  assign vmag = sum3[V_W-1] ? unsigned'(-sum3) : unsigned'(sum3);
  assign rnd  = vmag + V_W'(HALF_Q16);
  assign yw   = signed'({1'b0, rnd[V_W-1:Q16_SHIFT]});
  assign ymix = sum3[V_W-1] ? -yw : yw;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      out_valid <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o31  <= in_q.neg ? -o3p : o3p;
      x1   <= in_x;
      p12  <= P1_W'(signed'({1'b0, cfg.a})) * P1_W'(o31);
      p22  <= P2_W'(signed'({1'b0, wet})) * P2_W'(x1);
      o32  <= o31;
      mix2 <= (cfg.a < A_W'(HALF_Q16));
      sum3 <= V_W'(p12) + V_W'(p22);
      o33  <= o32;
      mix3 <= mix2;
      y4   <= mix3 ? ymix : Y_W'(o33);
      priority if (y4 > Y_W'(OMAX)) begin
        sample_out <= SAMPLE_WIDTH'(OMAX);
      end else if (y4 < Y_W'(OMIN)) begin
        sample_out <= SAMPLE_WIDTH'(OMIN);
      end else begin
        sample_out <= SAMPLE_WIDTH'(y4);
      end
    end
  end

endmodule

>>> src/diode_rectifier_waveshaper.sv
`timescale 1ns / 1ps
// Top level of the diode rectifier waveshaper
//
// One signed Q4.19 audio word in, one shaped Q4.19 word out, no state
// between words. Input channel: sample_in_valid / sample_in_stall with
// sample_in; output channel: sample_out_valid / sample_out_stall with
// sample_out. A word moves at a rising edge with valid high and stall low.
// The drive amount (Q0.16, values above 1.0 saturate) is written through
// cfg_write / cfg_data while no word is in flight; it takes effect for the
// next word accepted.
// From acceptance to the word shown on sample_out a word passes six
// stages of tanh lookup, gain and knee, ten stages of the restoring
// divider (two quotient bits a stage) and five stages of mix and saturation.
// Throughput is one word per cycle while the output word is not stalled.
// Synchronous reset empties the pipeline and sets the amount to zero;
// sample_in_stall is high during reset. While the output word is stalled
// the whole pipeline holds and sample_in_stall is raised in the same cycle.
module diode_rectifier_waveshaper #(
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int SAMPLE_WIDTH     = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [drw_pkg::A_W-1:0]        cfg_data,
  input  logic                           sample_in_valid,
  output logic                           sample_in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           sample_out_valid,
  input  logic                           sample_out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
  import drw_pkg::*;

  cfg_t                           cfg;
  logic [A_W-1:0]                 a_sat;
  logic                           adv;
  logic                           shp_valid;
  logic signed [SAMPLE_WIDTH-1:0] shp_x;
  dvd_t                           shp_d;
  logic                           div_valid;
  logic signed [SAMPLE_WIDTH-1:0] div_x;
  quo_t                           div_q;

  assign a_sat = (cfg_data > A_W'(ONE_Q16)) ? A_W'(ONE_Q16) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a    <= '0;
      cfg.gain <= GAIN_W'(ONE_Q16);
      cfg.den  <= DEN_W'(ONE_Q16);
    end else if (cfg_write) begin
      cfg.a    <= a_sat;
      cfg.gain <= GAIN_W'(a_sat) * GAIN_W'(GAIN_K) + GAIN_W'(ONE_Q16);
      cfg.den  <= DEN_W'(a_sat) * DEN_W'(DEN_K) + DEN_W'(ONE_Q16);
    end
  end

  assign adv             = !sample_out_valid || !sample_out_stall;
  assign sample_in_stall = rst || !adv;

  drw_shaper #(
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_shaper (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .cfg(cfg),
    .in_valid(sample_in_valid),
    .in_x(sample_in),
    .out_valid(shp_valid),
    .out_x(shp_x),
    .out_d(shp_d)
  );

  drw_divider #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_divider (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .den(cfg.den),
    .in_valid(shp_valid),
    .in_x(shp_x),
    .in_d(shp_d),
    .out_valid(div_valid),
    .out_x(div_x),
    .out_q(div_q)
  );

  drw_mixer #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mixer (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .cfg(cfg),
    .in_valid(div_valid),
    .in_x(div_x),
    .in_q(div_q),
    .out_valid(sample_out_valid),
    .sample_out(sample_out)
  );

endmodule

>>> src/drw_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the waveshaper and its binding to the top level
module drw_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    sample_in_valid,
  input logic                    sample_in_stall,
  input logic                    sample_out_valid,
  input logic                    sample_out_stall,
  input logic [SAMPLE_WIDTH-1:0] sample_out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !sample_out_valid)
    else $error("output word valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    sample_out_valid && sample_out_stall |=> sample_out_valid && $stable(sample_out))
    else $error("stalled output word dropped or changed");

  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    sample_out_valid && sample_out_stall |-> sample_in_stall)
    else $error("input taken while output word stalled");

  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    !sample_out_valid |-> !sample_in_stall)
    else $error("input stalled with empty output register");

endmodule

bind diode_rectifier_waveshaper drw_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_drw_checker (.*);
